@@ src/axts_pkg.sv @@
// Package: word types, command/status structs, AES and XTS helper functions.
package axts_pkg;

   typedef struct packed {
      logic        op;
      logic        first;
      logic [63:0] sector_hi;
      logic [63:0] sector_lo;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
   } axts_req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } axts_rsp_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_KEY_HI  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_KEY_LO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWEAK_KEY_HI = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TWEAK_KEY_LO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_BLKS  = 3'd4;

   localparam logic [15:0] SECTOR_BLKS_RESET = 16'd32;
   localparam logic [3:0]  LAST_ROUND        = 4'd10;
   localparam logic [3:0]  FIRST_ROUND       = 4'd1;
   localparam logic [7:0]  XTS_POLY          = 8'h87;
   localparam logic [7:0]  AES_POLY          = 8'h1b;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KLOAD,
      ST_KROUND,
      ST_TLOAD,
      ST_TROUND,
      ST_DLOAD,
      ST_DROUND,
      ST_FIN
   } axts_state_type;

   typedef struct packed {
      logic       capture;
      logic       kexp_load;
      logic       key_round;
      logic       k10_store;
      logic       tw_load;
      logic       tw_round;
      logic       tw_store;
      logic       dt_load;
      logic       dt_round;
      logic       out_load;
      logic [3:0] round;
   } axts_cmd_type;

   typedef struct packed {
      logic regen;
   } axts_status_type;

   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_BITS[2047 - 8*x -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] y);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (sbox(8'(i)) == y) r = 8'(i);
      end
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? AES_POLY : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] i);
      logic [7:0] r;
      unique case (i)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // byte k of a state sits at bits [127-8k -: 8]
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = sbox(s[127 - 8*(4*((c + r) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] =
               inv_sbox(s[127 - 8*(4*((c - r + 4) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
      logic [7:0] b [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      logic [7:0] x2, x4, x8;
      for (int i = 0; i < 4; i++) begin
         b[i]   = a[31 - 8*i -: 8];
         x2     = xtime(b[i]);
         x4     = xtime(x2);
         x8     = xtime(x4);
         m9[i]  = x8 ^ b[i];
         m11[i] = x8 ^ x2 ^ b[i];
         m13[i] = x8 ^ x4 ^ b[i];
         m14[i] = x8 ^ x4 ^ x2;
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
      return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
              inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
   endfunction

   function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
      return {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
   endfunction

   function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] n0, n1, n2, n3;
      n0 = k[127:96] ^ key_core(k[31:0], rc);
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = k[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w1, w2, w3;
      w3 = k[31:0] ^ k[63:32];
      w2 = k[63:32] ^ k[95:64];
      w1 = k[95:64] ^ k[127:96];
      return {k[127:96] ^ key_core(w3, rc), w1, w2, w3};
   endfunction

   // tweak is a little-endian byte string; multiply by x modulo the XTS polynomial
   function automatic logic [127:0] mul_alpha(input logic [127:0] t);
      logic [127:0] le, sh, r;
      for (int i = 0; i < 16; i++) begin
         le[8*i +: 8] = t[127 - 8*i -: 8];
      end
      sh = {le[126:0], 1'b0} ^ (le[127] ? {120'd0, XTS_POLY} : 128'd0);
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = sh[8*i +: 8];
      end
      return r;
   endfunction

endpackage

@@ src/axts_ctrl.sv @@
// Controller: sequences key expansion, tweak generation, data rounds and output.
module axts_ctrl
   import axts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_first,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  axts_status_type      status,
   output axts_cmd_type         cmd
);

   axts_state_type state_ff, state_in;
   logic [3:0]     rnd_ff, rnd_in;
   logic           dirty_ff, dirty_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           last_rnd;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_rnd  = (rnd_ff == LAST_ROUND);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) state_in = ST_KLOAD;
            else if (req_valid) state_in = (req_first || status.regen) ? ST_TLOAD : ST_DLOAD;
         end
         ST_KLOAD:  state_in = ST_KROUND;
         ST_KROUND: if (last_rnd) state_in = ST_IDLE;
         ST_TLOAD:  state_in = ST_TROUND;
         ST_TROUND: if (last_rnd) state_in = ST_DLOAD;
         ST_DLOAD:  state_in = ST_DROUND;
         ST_DROUND: if (last_rnd) state_in = ST_FIN;
         ST_FIN:    if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.round    = rnd_ff;
      req_ready    = 1'b0;
      rnd_in       = rnd_ff + 4'd1;
      dirty_in     = dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = !dirty_ff;
            cmd.capture = req_valid && !dirty_ff;
         end
         ST_KLOAD: begin
            cmd.kexp_load = 1'b1;
            dirty_in      = 1'b0;
            rnd_in        = FIRST_ROUND;
         end
         ST_KROUND: begin
            cmd.key_round = 1'b1;
            cmd.k10_store = last_rnd;
         end
         ST_TLOAD: begin
            cmd.tw_load = 1'b1;
            rnd_in      = FIRST_ROUND;
         end
         ST_TROUND: begin
            cmd.tw_round = 1'b1;
            cmd.tw_store = last_rnd;
         end
         ST_DLOAD: begin
            cmd.dt_load = 1'b1;
            rnd_in      = FIRST_ROUND;
         end
         ST_DROUND: cmd.dt_round = 1'b1;
         ST_FIN: begin
            cmd.out_load = slot_free;
            if (slot_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
      // a data key write restarts the schedule
      if (csr_we && (csr_index == CSR_DATA_KEY_HI || csr_index == CSR_DATA_KEY_LO))
         dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= FIRST_ROUND;
         dirty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/axts_dp.sv @@
// Datapath: key registers, AES round unit, tweak, sector counters, result register.
module axts_dp
   import axts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  axts_req_type         req_data,
   output axts_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   input  axts_cmd_type         cmd,
   output axts_status_type      status
);

   logic [127:0] dkey_ff, dkey_in;
   logic [127:0] tkey_ff, tkey_in;
   logic [15:0]  sblk_ff, sblk_in;
   logic [127:0] k10_ff, k10_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] tw_ff, tw_in;
   logic [127:0] tks_ff, tks_in;
   logic [127:0] sec_ff, sec_in;
   logic [15:0]  cnt_ff, cnt_in;
   logic         regen_ff, regen_in;
   axts_req_type cap_ff, cap_in;
   axts_rsp_type res_ff, res_in;

   logic [127:0] rk_fwd, rk_inv, enc_nxt, dec_pre, dec_nxt, key0, tw_key;
   logic [16:0]  cnt_nxt, limit;
   logic         last;

   assign last    = (cmd.round == LAST_ROUND);
   assign rk_fwd  = key_fwd(rk_ff, rcon(cmd.round));
   assign rk_inv  = key_inv(rk_ff, rcon(4'd11 - cmd.round));
   assign enc_nxt = (last ? sub_shift(st_ff) : mix_cols(sub_shift(st_ff))) ^ rk_fwd;
   assign dec_pre = inv_shift_sub(st_ff) ^ rk_inv;
   assign dec_nxt = last ? dec_pre : inv_mix_cols(dec_pre);
   assign key0    = cap_ff.op ? dkey_ff : k10_ff;
   // a deferred regeneration uses the tweak key as it stood when the sector ended
   assign tw_key  = cap_ff.first ? tkey_ff : tks_ff;
   assign cnt_nxt = {1'b0, cnt_ff} + 17'd1;
   assign limit   = (sblk_ff == 16'd0) ? 17'h10000 : {1'b0, sblk_ff};

   always_comb begin
      dkey_in = dkey_ff;
      tkey_in = tkey_ff;
      sblk_in = sblk_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DATA_KEY_HI:  dkey_in[127:64] = csr_wdata;
            CSR_DATA_KEY_LO:  dkey_in[63:0]   = csr_wdata;
            CSR_TWEAK_KEY_HI: tkey_in[127:64] = csr_wdata;
            CSR_TWEAK_KEY_LO: tkey_in[63:0]   = csr_wdata;
            CSR_SECTOR_BLKS:  sblk_in         = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cap_in   = cmd.capture ? req_data : cap_ff;
      k10_in   = cmd.k10_store ? rk_fwd : k10_ff;
      rk_in    = rk_ff;
      st_in    = st_ff;
      tw_in    = tw_ff;
      tks_in   = tks_ff;
      sec_in   = sec_ff;
      cnt_in   = cnt_ff;
      regen_in = regen_ff;
      res_in   = res_ff;
      if (cmd.kexp_load) rk_in = dkey_ff;
      if (cmd.key_round) rk_in = rk_fwd;
      if (cmd.tw_load) begin
         // a first word reloads the sector number, else the counter has moved on
         if (cap_ff.first) begin
            sec_in = {cap_ff.sector_hi, cap_ff.sector_lo};
            cnt_in = 16'd0;
         end
         st_in    = (cap_ff.first ? {cap_ff.sector_hi, cap_ff.sector_lo} : sec_ff) ^ tw_key;
         rk_in    = tw_key;
         regen_in = 1'b0;
      end
      if (cmd.tw_round) begin
         st_in = enc_nxt;
         rk_in = rk_fwd;
      end
      if (cmd.tw_store) tw_in = enc_nxt;
      if (cmd.dt_load) begin
         st_in = {cap_ff.block_hi, cap_ff.block_lo} ^ tw_ff ^ key0;
         rk_in = key0;
      end
      if (cmd.dt_round) begin
         st_in = cap_ff.op ? enc_nxt : dec_nxt;
         rk_in = cap_ff.op ? rk_fwd : rk_inv;
      end
      if (cmd.out_load) begin
         res_in = st_ff ^ tw_ff;
         tw_in  = mul_alpha(tw_ff);
         if (cnt_nxt >= limit) begin
            cnt_in   = 16'd0;
            sec_in   = sec_ff + 128'd1;
            regen_in = 1'b1;
            tks_in   = tkey_ff;
         end else begin
            cnt_in = cnt_nxt[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dkey_ff  <= '0;
         tkey_ff  <= '0;
         sblk_ff  <= SECTOR_BLKS_RESET;
         sec_ff   <= '0;
         cnt_ff   <= '0;
         regen_ff <= 1'b0;
      end else begin
         dkey_ff  <= dkey_in;
         tkey_ff  <= tkey_in;
         sblk_ff  <= sblk_in;
         sec_ff   <= sec_in;
         cnt_ff   <= cnt_in;
         regen_ff <= regen_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      k10_ff <= k10_in;
      rk_ff  <= rk_in;
      st_ff  <= st_in;
      tw_ff  <= tw_in;
      tks_ff <= tks_in;
      res_ff <= res_in;
   end

   assign rsp_data     = res_ff;
   assign status.regen = regen_ff;

endmodule

@@ src/aes128_xts_sector_cipher.sv @@
// AES-128 XTS sector cipher, one 16-byte word per request.
// Each word runs load, ten rounds and finish; before it the tweak is regenerated (load
// and ten rounds) for the first word of a request or of a new sector.
// No new word is taken until the last one has finished; the single round unit is shared.
// After a data key write, req_ready stays low while the key schedule runs.
// Reset (synchronous): keys clear, sector size 32, counters zero, schedule rerun.
module aes128_xts_sector_cipher
   import axts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  axts_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output axts_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   axts_cmd_type    cmd;
   axts_status_type status;

   axts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_first (req_data.first),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   axts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result written over a pending word");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.tw_load || cmd.dt_load))
      else $error("accepted word not loaded");

   a_tweak_then_data: assert property (@(posedge clock) disable iff (reset)
      cmd.tw_store |=> cmd.dt_load)
      else $error("tweak not followed by data pass");

endmodule

@@ test/tb_aes128_xts_sector_cipher.sv @@
// Self-checking testbench for the AES-128 XTS sector cipher: directed table, then random phases.
module tb_aes128_xts_sector_cipher;
   timeunit 1ns;
   timeprecision 1ps;
   import axts_pkg::*;

   localparam logic OP_DEC = 1'b0;
   localparam logic OP_ENC = 1'b1;
   localparam int LIMIT = 500000;
   localparam int SETTLE = 30;        // lets the block return to idle
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_WORD = 350;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 88;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   axts_req_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   axts_rsp_type         rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;

   aes128_xts_sector_cipher dut (.*);

   always #1 clock = ~clock;

   typedef struct {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [63:0]          val;
      axts_req_type         w;
      bit                   chk;
      axts_rsp_type         exp;
   } row_type;

   // cipher mirror
   logic [7:0]          fwd_sb [256];
   logic [7:0]          inv_sb [256];
   logic [10:0][127:0]  data_rk, tweak_rk;
   logic [63:0]         dk_hi, dk_lo, tk_hi, tk_lo;
   logic [15:0]         sect_blks;
   logic [127:0]        tweak_cur, sector_cur;
   int unsigned         blk_cnt;

   axts_rsp_type result_q [$];
   int  mismatches = 0;
   int  sent = 0;
   int  cycles = 0;
   bit  src_quiet, sink_quiet, hold_req, hold_done = 0;
   int  stall_left = 0;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   task automatic build_sbox();
      logic [7:0] inv, p, b;
      int e;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         p = 8'(x);
         e = 254;
         while (e != 0) begin
            if (e & 1) inv = gf_mul(inv, p);
            p = gf_mul(p, p);
            e = e >> 1;
         end
         b = inv;
         fwd_sb[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                     ^ {b[3:0], b[7:4]} ^ 8'h63;
         inv_sb[fwd_sb[x]] = 8'(x);
      end
   endtask

   function automatic logic [10:0][127:0] expand_key(input logic [63:0] hi,
                                                      input logic [63:0] lo);
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      logic [10:0][127:0] rk;
      rc = 8'h01;
      w[0] = hi[63:32]; w[1] = hi[31:0]; w[2] = lo[63:32]; w[3] = lo[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
            t[31:24] ^= rc;
            rc = gf_mul(rc, 8'h02);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int i = 0; i < 11; i++) rk[i] = {w[4*i], w[4*i+1], w[4*i+2], w[4*i+3]};
      return rk;
   endfunction

   // byte k of a 128-bit state sits at [127-8k -: 8]
   function automatic logic [127:0] fwd_round(input logic [127:0] s, input bit last);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(4*c + r) -: 8] = fwd_sb[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32*c -: 8]; a1 = t[119 - 32*c -: 8];
            a2 = t[111 - 32*c -: 8]; a3 = t[103 - 32*c -: 8];
            t[127 - 32*c -: 8] = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
            t[119 - 32*c -: 8] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
            t[111 - 32*c -: 8] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
            t[103 - 32*c -: 8] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(4*c + r) -: 8] = inv_sb[s[127 - 8*(4*((c - r + 4) % 4) + r) -: 8]];
      return t;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8]; a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8]; a3 = s[103 - 32*c -: 8];
         t[127 - 32*c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                              ^ gf_mul(a3, 8'd9);
         t[119 - 32*c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                              ^ gf_mul(a3, 8'd13);
         t[111 - 32*c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                              ^ gf_mul(a3, 8'd11);
         t[103 - 32*c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                              ^ gf_mul(a3, 8'd14);
      end
      return t;
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] s,
                                                input logic [10:0][127:0] rk);
      s ^= rk[0];
      for (int r = 1; r <= 10; r++) s = fwd_round(s, r == 10) ^ rk[r];
      return s;
   endfunction

   function automatic logic [127:0] aes_decrypt(input logic [127:0] s,
                                                input logic [10:0][127:0] rk);
      s ^= rk[10];
      for (int r = 9; r >= 0; r--) begin
         s = inv_sub_shift(s) ^ rk[r];
         if (r != 0) s = inv_mix(s);
      end
      return s;
   endfunction

   // tweak read as a little-endian byte string, times alpha
   function automatic logic [127:0] tweak_times_alpha(input logic [127:0] t);
      logic [127:0] le, r;
      logic         carry;
      for (int i = 0; i < 16; i++) le[8*i +: 8] = t[127 - 8*i -: 8];
      carry = le[127];
      le = le << 1;
      if (carry) le[7:0] ^= XTS_POLY;
      for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = le[8*i +: 8];
      return r;
   endfunction

   function automatic void csr_mirror(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      case (idx)
         CSR_DATA_KEY_HI:  dk_hi = v;
         CSR_DATA_KEY_LO:  dk_lo = v;
         CSR_TWEAK_KEY_HI: tk_hi = v;
         CSR_TWEAK_KEY_LO: tk_lo = v;
         CSR_SECTOR_BLKS:  sect_blks = v[15:0];
         default: ;
      endcase
      if (idx == CSR_DATA_KEY_HI || idx == CSR_DATA_KEY_LO) data_rk = expand_key(dk_hi, dk_lo);
      if (idx == CSR_TWEAK_KEY_HI || idx == CSR_TWEAK_KEY_LO)
         tweak_rk = expand_key(tk_hi, tk_lo);
   endfunction

   function automatic axts_rsp_type xts_word(input axts_req_type w);
      logic [127:0] b;
      int unsigned  size;
      if (w.first) begin
         sector_cur = {w.sector_hi, w.sector_lo};
         blk_cnt = 0;
         tweak_cur = aes_encrypt(sector_cur, tweak_rk);
      end
      b = {w.block_hi, w.block_lo} ^ tweak_cur;
      b = (w.op == OP_ENC) ? aes_encrypt(b, data_rk) : aes_decrypt(b, data_rk);
      b ^= tweak_cur;
      tweak_cur = tweak_times_alpha(tweak_cur);
      size = (sect_blks == 16'd0) ? 65536 : sect_blks;
      if (blk_cnt + 1 >= size) begin
         blk_cnt = 0;
         sector_cur = sector_cur + 128'd1;
         tweak_cur = aes_encrypt(sector_cur, tweak_rk);
      end else begin
         blk_cnt = blk_cnt + 1;
      end
      return '{result_hi: b[127:64], result_lo: b[63:0]};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] pick_wide();
      case ($urandom_range(0, 3))
         0: return 64'd0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic row_type cfg_row(input logic [CSR_IDX_W-1:0] i, input logic [63:0] v);
      row_type r;
      r.is_cfg = 1'b1; r.idx = i; r.val = v; r.w = '0; r.chk = 1'b0; r.exp = '0;
      return r;
   endfunction

   function automatic row_type word_row(input logic op, input logic first,
                                        input logic [63:0] shi, input logic [63:0] slo,
                                        input logic [63:0] bhi, input logic [63:0] blo,
                                        input bit chk, input logic [127:0] exp);
      row_type r;
      r.is_cfg = 1'b0; r.idx = CSR_DATA_KEY_HI; r.val = '0;
      r.w = '{op: op, first: first, sector_hi: shi, sector_lo: slo,
              block_hi: bhi, block_lo: blo};
      r.chk = chk;
      r.exp = '{result_hi: exp[127:64], result_lo: exp[63:0]};
      return r;
   endfunction

   task automatic send_word(input axts_req_type w, input bit chk, input axts_rsp_type exp);
      int g;
      axts_rsp_type p;
      csr_we <= 1'b0;
      g = src_quiet ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = xts_word(w);
      result_q.push_back(chk ? exp : p);
      sent++;
      if (sent == HOLD_AT_WORD) hold_req <= 1'b1;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_we <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes; the next word or drain drops it
   task automatic csr_write(input logic [CSR_IDX_W-1:0] i, input logic [63:0] v);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      csr_mirror(i, v);
   endtask

   // receiver: random stalls, one long hold-off to back the block up
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         stall_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 9) < 3) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      axts_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            e = result_q.pop_front();
            if (rsp_data.result_hi !== e.result_hi || rsp_data.result_lo !== e.result_lo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %h_%h got %h_%h", e.result_hi,
                           e.result_lo, rsp_data.result_hi, rsp_data.result_lo);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      row_type plan [$];
      axts_req_type w;
      bit idle;
      logic [15:0] size;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_DATA_KEY_HI;
      csr_wdata = '0;
      src_quiet = 0; sink_quiet = 0; hold_req = 0;
      build_sbox();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all-zero keys at sector 0 give the standard XTS test vector
      plan.push_back(cfg_row(CSR_DATA_KEY_HI, 64'd0));
      plan.push_back(cfg_row(CSR_DATA_KEY_LO, 64'd0));
      plan.push_back(cfg_row(CSR_TWEAK_KEY_HI, 64'd0));
      plan.push_back(cfg_row(CSR_TWEAK_KEY_LO, 64'd0));
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'd32));
      plan.push_back(word_row(OP_ENC, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1,
                              128'h917cf69ebd68b2ec9b9fe9a3eadda692));
      plan.push_back(word_row(OP_ENC, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1,
                              128'hcd43d2f59598ed858c02c2652fbf922e));
      plan.push_back(word_row(OP_DEC, 1'b1, 64'd0, 64'd0, 64'h917cf69ebd68b2ec,
                              64'h9b9fe9a3eadda692, 1'b1, 128'd0));
      plan.push_back(word_row(OP_DEC, 1'b0, 64'd0, 64'd0, 64'hcd43d2f59598ed85,
                              64'h8c02c2652fbf922e, 1'b1, 128'd0));
      plan.push_back(word_row(OP_ENC, 1'b1, ONES, ONES, ONES, ONES, 1'b0, 128'd0));
      plan.push_back(word_row(OP_DEC, 1'b0, 64'd0, 64'd0, ONES, ONES, 1'b0, 128'd0));
      // one-block sectors from the top sector number: wraps to zero
      plan.push_back(cfg_row(CSR_DATA_KEY_HI, ONES));
      plan.push_back(cfg_row(CSR_DATA_KEY_LO, ONES));
      plan.push_back(cfg_row(CSR_TWEAK_KEY_HI, ONES));
      plan.push_back(cfg_row(CSR_TWEAK_KEY_LO, ONES));
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'd1));
      plan.push_back(word_row(OP_ENC, 1'b1, ONES, ONES, 64'd0, 64'd0, 1'b0, 128'd0));
      plan.push_back(word_row(OP_DEC, 1'b0, 64'd0, 64'd0, 64'h0123456789abcdef,
                              64'hfedcba9876543210, 1'b0, 128'd0));
      plan.push_back(word_row(OP_ENC, 1'b0, 64'd0, 64'd0, 64'h8000000000000001,
                              64'h7ffffffffffffffe, 1'b0, 128'd0));
      // zero size means 65536 blocks; upper data bits are ignored
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'hFFFF_FFFF_FFFF_0000));
      plan.push_back(word_row(OP_ENC, 1'b1, 64'd0, ONES, 64'h5555aaaa5555aaaa,
                              64'haaaa5555aaaa5555, 1'b0, 128'd0));
      plan.push_back(word_row(OP_DEC, 1'b0, 64'd0, 64'd0, 64'h1, 64'h2, 1'b0, 128'd0));
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'd65535));
      plan.push_back(word_row(OP_ENC, 1'b1, 64'h1, 64'd0, 64'h3, 64'h4, 1'b0, 128'd0));
      plan.push_back(word_row(OP_DEC, 1'b0, 64'd0, 64'd0, 64'h5, 64'h6, 1'b0, 128'd0));
      // sector size lowered mid-sector: count already past the new size
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'd8));
      for (int i = 0; i < 5; i++)
         plan.push_back(word_row(i[0], i == 0, 64'h10, 64'h20, {$urandom, $urandom},
                                 {$urandom, $urandom}, 1'b0, 128'd0));
      plan.push_back(cfg_row(CSR_SECTOR_BLKS, 64'd3));
      plan.push_back(word_row(OP_ENC, 1'b0, 64'd0, 64'd0, 64'h7, 64'h8, 1'b0, 128'd0));
      plan.push_back(word_row(OP_ENC, 1'b0, 64'd0, 64'd0, 64'h9, 64'ha, 1'b0, 128'd0));

      idle = 1;
      foreach (plan[n]) begin
         if (plan[n].is_cfg) begin
            if (!idle) drain();
            idle = 1;
            csr_write(plan[n].idx, plan[n].val);
         end else begin
            send_word(plan[n].w, plan[n].chk, plan[n].exp);
            idle = 0;
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         csr_write(CSR_DATA_KEY_HI, pick_wide());
         csr_write(CSR_DATA_KEY_LO, pick_wide());
         csr_write(CSR_TWEAK_KEY_HI, pick_wide());
         csr_write(CSR_TWEAK_KEY_LO, pick_wide());
         case ($urandom_range(0, 5))
            0: size = 16'd1;
            1: size = 16'd2;
            2: size = 16'($urandom_range(3, 8));
            3: size = 16'd65535;
            4: size = 16'd0;
            default: size = 16'($urandom_range(1, 64));
         endcase
         csr_write(CSR_SECTOR_BLKS, {$urandom, 16'($urandom), size});
         src_quiet = (ph % 3 == 1);
         sink_quiet = (ph % 3 == 1);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            w.op = 1'($urandom_range(0, 1));
            w.first = (k == 0) || ($urandom_range(0, 11) == 0);
            w.sector_hi = pick_wide();
            w.sector_lo = pick_wide();
            w.block_hi = {$urandom, $urandom};
            w.block_lo = {$urandom, $urandom};
            send_word(w, 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
